>>> rtl/npcs_pkg.sv
// Package with the constants and controller/datapath interface types of the palette search.
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int IDX_W           = 8;
   localparam int CHAN_W          = 8;
   localparam int DAC_W           = 6;
   localparam int WORD_W          = 3 * DAC_W;
   localparam int SQ_W            = 2 * CHAN_W;
   localparam int DIST_W          = SQ_W + 2;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic write;
      logic load_query;
      logic issue;
   } npcs_cmd_type;

   typedef struct packed {
      logic last_addr;
      logic pipe_idle;
   } npcs_status_type;

endpackage

`default_nettype wire

>>> rtl/npcs_ctrl.sv
// Controller state machine that sequences palette writes and the query scan.
`timescale 1ns / 1ps
`default_nettype none

module npcs_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      req_action,
   output logic                           busy,
   output logic                           rsp_valid,
   output npcs_pkg::npcs_cmd_type         cmd,
   input  wire npcs_pkg::npcs_status_type status
);
   import npcs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in       = state_ff;
      busy           = 1'b1;
      rsp_valid      = 1'b0;
      cmd.write      = 1'b0;
      cmd.load_query = 1'b0;
      cmd.issue      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action == ACTION_QUERY) begin
                  cmd.load_query = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The best index is final once the last entry has left the pipeline.
            if (status.pipe_idle) begin
               rsp_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/npcs_datapath.sv
// Datapath with the palette memory, distance pipeline and best-match tracking.
`timescale 1ns / 1ps
`default_nettype none

module npcs_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire npcs_pkg::npcs_cmd_type    cmd,
   output npcs_pkg::npcs_status_type      status,
   input  wire logic [7:0]                req_entry_index,
   input  wire logic [7:0]                req_red,
   input  wire logic [7:0]                req_green,
   input  wire logic [7:0]                req_blue,
   output logic [7:0]                     rsp_match_index
);
   import npcs_pkg::*;

   logic [WORD_W-1:0]          mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] written_ff;

   logic              wr_in_range;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_word;

   logic [CHAN_W-1:0] q_red_ff, q_green_ff, q_blue_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Read stage.
   logic              rd_v_ff;
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_written_ff;
   logic [ADDR_W-1:0] rd_idx_ff;

   // Square stage.
   logic              sq_v_ff;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [ADDR_W-1:0] sq_idx_ff;

   logic [DIST_W-1:0] best_dist_ff;
   logic [ADDR_W-1:0] best_idx_ff;

   logic [WORD_W-1:0] entry;
   logic [CHAN_W-1:0] p_red, p_green, p_blue;
   logic [CHAN_W-1:0] d_red, d_green, d_blue;
   logic [SQ_W-1:0]   sq_r_in, sq_g_in, sq_b_in;
   logic [DIST_W-1:0] dist_sum;

   assign wr_in_range = ({1'b0, req_entry_index} < 9'(PALETTE_ENTRIES));
   assign wr_addr     = ADDR_W'(req_entry_index);
   assign wr_word     = {req_red[CHAN_W-1 -: DAC_W], req_green[CHAN_W-1 -: DAC_W],
                         req_blue[CHAN_W-1 -: DAC_W]};

   // Entries never written since reset read as black.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (cmd.write && wr_in_range) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         mem[wr_addr] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff    <= mem[addr_ff];
      rd_written_ff <= written_ff[addr_ff];
      rd_idx_ff     <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_red_ff   <= req_red;
         q_green_ff <= req_green;
         q_blue_ff  <= req_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.load_query) begin
         addr_ff <= '0;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + ADDR_W'(1);
      end
   end

   assign entry   = rd_written_ff ? rd_word_ff : '0;
   assign p_red   = {entry[3*DAC_W-1 -: DAC_W], 2'b00};
   assign p_green = {entry[2*DAC_W-1 -: DAC_W], 2'b00};
   assign p_blue  = {entry[DAC_W-1 -: DAC_W], 2'b00};

   assign d_red   = (q_red_ff > p_red) ? (q_red_ff - p_red) : (p_red - q_red_ff);
   assign d_green = (q_green_ff > p_green) ? (q_green_ff - p_green) : (p_green - q_green_ff);
   assign d_blue  = (q_blue_ff > p_blue) ? (q_blue_ff - p_blue) : (p_blue - q_blue_ff);

   assign sq_r_in = SQ_W'(d_red) * SQ_W'(d_red);
   assign sq_g_in = SQ_W'(d_green) * SQ_W'(d_green);
   assign sq_b_in = SQ_W'(d_blue) * SQ_W'(d_blue);

   always_ff @(posedge clock) begin
      sq_r_ff   <= sq_r_in;
      sq_g_ff   <= sq_g_in;
      sq_b_ff   <= sq_b_in;
      sq_idx_ff <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.issue;
         sq_v_ff <= rd_v_ff;
      end
   end

   assign dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // The all-ones start value exceeds any real distance, so the first entry always wins,
   // and the strict compare keeps the lowest index among equal distances.
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (sq_v_ff && (dist_sum < best_dist_ff)) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= sq_idx_ff;
      end
   end

   assign status.last_addr = (addr_ff == ADDR_W'(PALETTE_ENTRIES - 1));
   assign status.pipe_idle = !rd_v_ff && !sq_v_ff;
   assign rsp_match_index  = IDX_W'(best_idx_ff);

endmodule

`default_nettype wire

>>> rtl/nearest_palette_color_search_unit.sv
// Top level of the nearest palette color search unit.
//
//   channel   | ports                                          | handshake
//   ----------+------------------------------------------------+----------------------
//   request   | req_action, req_entry_index, req_red/green/blue | start high, busy low
//   response  | rsp_match_index                                | rsp_valid, one cycle
//
// A write item is taken while idle and gives no result; busy stays low.
// A query item holds busy while the palette, whose memory has one read
// port, is scanned: the scan reads and compares one entry per cycle, then drains a two-stage
// distance pipeline; rsp_valid is high in the last cycle in which busy is high.
// Synchronous reset clears the control state and marks every palette entry as black.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_search_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_action,
   input  wire logic [7:0] req_entry_index,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output logic            rsp_valid,
   output logic [7:0]      rsp_match_index
);
   import npcs_pkg::*;

   npcs_cmd_type    cmd;
   npcs_status_type status;

   npcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .status     (status)
   );

   npcs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_match_index (rsp_match_index)
   );

endmodule

`default_nettype wire
